// File: design/cursor_sequence_list_macros.svh
// ----------------------------------------------------------------------------
// Cursor sequence list assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_LIST_MACROS_SVH
`define CURSOR_SEQUENCE_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cursor sequence list assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cursor sequence list assertion failed");

`endif

// File: design/csl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor sequence list package
// Sizes, operation and status codes, and the types passed between modules.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned CAPACITY_ITEMS = 32;
  localparam int unsigned VALUE_WIDTH    = 32;

  localparam int unsigned ADDR_W      = $clog2(CAPACITY_ITEMS);
  localparam int unsigned CNT_W       = $clog2(CAPACITY_ITEMS + 1);
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned OUT_IDX_W   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 3'd0,
    FUNC_ADVANCE = 3'd1,
    FUNC_INSERT  = 3'd2,
    FUNC_ATTACH  = 3'd3,
    FUNC_REMOVE  = 3'd4
  } csl_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_NO_CURRENT = 2'd2
  } csl_status_e;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } csl_mem_req_t;

  typedef struct packed {
    csl_status_e            status;
    logic                   has_current;
    logic [OUT_VALUE_W-1:0] current_value;
    logic [OUT_IDX_W-1:0]   cursor_index;
    logic [OUT_IDX_W-1:0]   item_count;
  } csl_result_t;

endpackage

// File: design/cursor_sequence_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor sequence list
// Ordered list of values in a memory, with a cursor and five list operations.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Start, advance and any failed
// operation read back the current item when one remains. Insert and attach
// move the stored entries from the new position onward up one place and
// then write the new value; remove moves the entries after the cursor down
// one place and then reads back the current item. The shift through the
// item memory runs one entry per cycle over its single write port. A
// finished result waits in an output register, and the next item is
// accepted while it waits.
module cursor_sequence_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [csl_pkg::FUNC_W-1:0]         func_i,
  input  logic [csl_pkg::IN_VALUE_W-1:0]     new_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [csl_pkg::STATUS_W-1:0]       status_o,
  output logic                               has_current_o,
  output logic [csl_pkg::OUT_VALUE_W-1:0]    current_value_o,
  output logic [csl_pkg::OUT_IDX_W-1:0]      cursor_index_o,
  output logic [csl_pkg::OUT_IDX_W-1:0]      item_count_o
);

  import csl_pkg::*;

  csl_result_t            res;
  logic                   res_valid;
  logic                   res_ready;
  csl_mem_req_t           mem_req;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  csl_result_t            out_q;
  logic                   out_valid_q;

  csl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .new_value_i (new_value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  csl_mem #(
    .DEPTH (CAPACITY_ITEMS),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign has_current_o   = out_q.has_current;
  assign current_value_o = out_q.current_value;
  assign cursor_index_o  = out_q.cursor_index;
  assign item_count_o    = out_q.item_count;

endmodule

// File: design/csl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor sequence list item memory
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module csl_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/csl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor sequence list controller
// Sequencer that decodes an item, shifts stored entries through the memory
// one per cycle, writes the new value or reads back the current item.
// ----------------------------------------------------------------------------
module csl_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [csl_pkg::FUNC_W-1:0]          func_i,
  input  logic [csl_pkg::IN_VALUE_W-1:0]      new_value_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output csl_pkg::csl_result_t                res_o,
  output csl_pkg::csl_mem_req_t               mem_req_o,
  input  logic [csl_pkg::VALUE_WIDTH-1:0]     mem_rdata_i
);

  import csl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_WRNEW,
    ST_READ,
    ST_RDATA,
    ST_RESULT
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cursor_q, cursor_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       end_q, end_d;
  logic                   down_q, down_d;
  logic                   pend_q, pend_d;
  logic [ADDR_W-1:0]      pend_addr_q, pend_addr_d;
  logic                   wr_new_q, wr_new_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] cur_val_q, cur_val_d;
  csl_status_e            status_q, status_d;

  logic             accept;
  logic             at_item;
  logic             full;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] idx_next;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign at_item     = (cursor_q < count_q);
  assign full        = (count_q >= CNT_W'(CAPACITY_ITEMS));
  assign idx_next    = down_q ? (idx_q + 1'b1) : (idx_q - 1'b1);
  assign res_valid_o = (state_q == ST_RESULT);

  assign res_o.status        = status_q;
  assign res_o.has_current   = at_item;
  assign res_o.current_value = OUT_VALUE_W'(cur_val_q);
  assign res_o.cursor_index  = OUT_IDX_W'(cursor_q);
  assign res_o.item_count    = OUT_IDX_W'(count_q);

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    idx_d       = idx_q;
    end_d       = end_q;
    down_d      = down_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    wr_new_d    = wr_new_q;
    val_d       = val_q;
    cur_val_d   = cur_val_q;
    status_d    = status_q;
    pos         = '0;
    mem_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d    = VALUE_WIDTH'(new_value_i);
          status_d = STATUS_OK;
          wr_new_d = 1'b0;
          pend_d   = 1'b0;
          state_d  = ST_READ;
          unique case (csl_func_e'(func_i))
            FUNC_START: begin
              if (count_q != '0) begin
                cursor_d = '0;
              end
            end
            FUNC_ADVANCE: begin
              if (at_item) begin
                cursor_d = cursor_q + 1'b1;
              end
            end
            FUNC_INSERT: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                pos      = at_item ? cursor_q : '0;
                cursor_d = pos;
                count_d  = count_q + 1'b1;
                idx_d    = count_q;
                end_d    = pos;
                down_d   = 1'b0;
                wr_new_d = 1'b1;
                state_d  = ST_SHIFT;
              end
            end
            FUNC_ATTACH: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                pos      = at_item ? (cursor_q + 1'b1) : count_q;
                cursor_d = pos;
                count_d  = count_q + 1'b1;
                idx_d    = count_q;
                end_d    = pos;
                down_d   = 1'b0;
                wr_new_d = 1'b1;
                state_d  = ST_SHIFT;
              end
            end
            FUNC_REMOVE: begin
              if (!at_item) begin
                status_d = STATUS_NO_CURRENT;
              end else begin
                count_d = count_q - 1'b1;
                idx_d   = cursor_q;
                end_d   = count_q - 1'b1;
                down_d  = 1'b1;
                state_d = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Each read returns in the next cycle and is written one place over.
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pend_addr_q;
          mem_req_o.wdata = mem_rdata_i;
        end
        if (idx_q != end_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_next[ADDR_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_q[ADDR_W-1:0];
          idx_d           = idx_next;
        end else begin
          pend_d  = 1'b0;
          state_d = wr_new_q ? ST_WRNEW : ST_READ;
        end
      end
      ST_WRNEW: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cursor_q[ADDR_W-1:0];
        mem_req_o.wdata = val_q;
        cur_val_d       = val_q;
        state_d         = ST_RESULT;
      end
      ST_READ: begin
        if (at_item) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cursor_q[ADDR_W-1:0];
          state_d         = ST_RDATA;
        end else begin
          cur_val_d = '0;
          state_d   = ST_RESULT;
        end
      end
      ST_RDATA: begin
        cur_val_d = mem_rdata_i;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      down_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      wr_new_q    <= 1'b0;
      val_q       <= '0;
      cur_val_q   <= '0;
      status_q    <= STATUS_OK;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      down_q      <= down_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      wr_new_q    <= wr_new_d;
      val_q       <= val_d;
      cur_val_q   <= cur_val_d;
      status_q    <= status_d;
    end
  end

endmodule

// File: design/csl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor sequence list checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_sequence_list_macros.svh"

module csl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [csl_pkg::STATUS_W-1:0]       status_o,
  input logic                               has_current_o,
  input logic [csl_pkg::OUT_VALUE_W-1:0]    current_value_o,
  input logic [csl_pkg::OUT_IDX_W-1:0]      cursor_index_o,
  input logic [csl_pkg::OUT_IDX_W-1:0]      item_count_o
);

  logic                                       in_accept;
  logic [$bits(csl_pkg::csl_result_t)-1:0]   out_bundle;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_bundle = {status_o, has_current_o, current_value_o, cursor_index_o,
                       item_count_o};

  `CSL_ASSERT_NOW(a_current_flag, out_valid_o, has_current_o == (cursor_index_o != item_count_o))

  `CSL_ASSERT_NOW(a_no_current_zero, out_valid_o && !has_current_o, current_value_o == '0)

  `CSL_ASSERT_NOW(a_cursor_range, out_valid_o, cursor_index_o <= item_count_o)

  `CSL_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o)

  `CSL_ASSERT_NEXT(a_result_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_bundle))

endmodule

bind cursor_sequence_list csl_checker u_csl_checker (.*);
